[sv/sntp_reply_time_extract_unit_assert.svh]
// Assertion macros for the SNTP reply time extraction unit.
`ifndef SNTP_REPLY_TIME_EXTRACT_UNIT_ASSERT_SVH
`define SNTP_REPLY_TIME_EXTRACT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SRTE_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("SNTP time extract assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SRTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("SNTP time extract assertion failed");
`else
`define SRTE_ASSERT(lbl, clk, rstn, ante, cons)
`define SRTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[sv/srte_pkg.sv]
// Package with constants, pipeline types and helper functions of the SNTP time extractor.
package srte_pkg;

  localparam int unsigned MAX_ROUNDTRIP_SEC = 2;
  localparam int unsigned DIFF_W = $clog2(MAX_ROUNDTRIP_SEC + 1);

  localparam logic [15:0] LEN_SNTP    = 16'd48;
  localparam logic [7:0]  MODE_MASK   = 8'h3F;
  localparam logic [7:0]  MODE_SERVER = 8'h1C;
  localparam logic [7:0]  LEAP_MASK   = 8'hC0;
  localparam logic [31:0] ROUND_HALF  = 32'd32768;

  localparam logic [31:0] EPOCH_RESET  = 32'd3155673600;
  localparam logic [16:0] PERIOD_RESET = 17'd62500;

  // Long division of the 32-bit total by the 17-bit period.
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES = 32 / DIV_BITS_PER_STAGE;

  // Edges from an accepting edge to the edge that samples the result strobe.
  localparam int unsigned LAT_EDGES = DIV_STAGES + 4;

  typedef enum logic [1:0] {
    CFG_EPOCH  = 2'd0,
    CFG_RT     = 2'd1,
    CFG_PERIOD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              ok;
    logic [31:0]       secs;
    logic [31:0]       psum_a;
    logic [31:0]       psum_b;
    logic [DIFF_W-1:0] diff;
    logic [15:0]       lsub;
    logic [31:0]       osub;
  } s1_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] secs;
    logic [15:0] count;
    logic [31:0] delay;
  } s2_t;

  typedef struct packed {
    logic        ok;
    logic        do_div;
    logic [31:0] secs;
    logic [15:0] byp;
    logic [16:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
  } div_stage_t;

  function automatic logic [31:0] swap32(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Several restoring division steps; the remainder stays below the divisor.
  function automatic div_stage_t div_step(div_stage_t s, logic [16:0] d);
    div_stage_t r;
    logic [17:0] t;
    r = s;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      t     = {r.rem, r.num[31]};
      r.num = {r.num[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.quo = {r.quo[30:0], 1'b1};
      end else begin
        r.quo = {r.quo[30:0], 1'b0};
      end
      r.rem = t[16:0];
    end
    return r;
  endfunction

endpackage

[sv/sntp_reply_time_extract_unit.sv]
// SNTP reply time extraction unit: checks a server reply and derives the new local time.
// The unit is a fully pipelined datapath that takes one reply word per clock
// and never asserts busy_o, so start_i may be held high every cycle. The
// result strobe done_o rises once the word has left the final stage, and the
// result is on the ports for that single cycle;
// the receiver cannot stall, so it must capture the word when done_o is high.
// Depth is set by the divider that splits the corrected subsecond total into
// whole seconds and a timer count: it resolves four quotient bits per stage
// over eight stages, after three stages of checks, fraction scaling and delay
// arithmetic, and one final stage that adds the carry into the seconds.
// A refused reply still yields a word, with valid_res_o low and zero time.
// Configuration words are taken every cycle (cfg_ready_o is always high) and
// should only be written while no reply is in flight; an index outside the
// register list is ignored.
`include "sntp_reply_time_extract_unit_assert.svh"

module sntp_reply_time_extract_unit
  import srte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Reply word in.
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] packet_length_i,
  input  logic [7:0]  version_mode_i,
  input  logic [31:0] origin_seconds_i,
  input  logic [31:0] origin_subcount_i,
  input  logic [31:0] transmit_seconds_raw_i,
  input  logic [31:0] transmit_fraction_raw_i,
  input  logic [31:0] local_seconds_i,
  input  logic [15:0] local_subcount_i,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Result word out.
  output logic        done_o,
  output logic        valid_res_o,
  output logic [31:0] new_seconds_o,
  output logic [15:0] new_subcount_o
);

  // Configuration registers.
  logic [31:0] epoch_q;
  logic        rt_en_q;
  logic [16:0] period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q  <= EPOCH_RESET;
      rt_en_q  <= 1'b0;
      period_q <= PERIOD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_EPOCH:  epoch_q  <= cfg_data_i;
        CFG_RT:     rt_en_q  <= cfg_data_i[0];
        CFG_PERIOD: period_q <= cfg_data_i[16:0];
        default:    ;
      endcase
    end
  end

  // The pipeline never stalls, so a word is taken whenever start_i is high.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Stage 1: header checks, byte swap, seconds offset, the round-trip window
  // test and both partial sums of the fraction scaling.
  logic [31:0] tsec;
  logic [31:0] tfrac;
  logic [31:0] rt_diff;
  logic        hdr_ok;
  logic        rt_bad;
  s1_t         s1_d;
  s1_t         s1_q;
  logic        s1_vld_q;

  always_comb begin
    tsec    = swap32(transmit_seconds_raw_i);
    tfrac   = swap32(transmit_fraction_raw_i);
    rt_diff = local_seconds_i - origin_seconds_i;
    hdr_ok  = (packet_length_i == LEN_SNTP) &&
              ((version_mode_i & MODE_MASK) == MODE_SERVER) &&
              ((version_mode_i & LEAP_MASK) != LEAP_MASK) &&
              ((transmit_seconds_raw_i != 32'd0) || (transmit_fraction_raw_i != 32'd0));
    // The originate stamp must not lie after local time, nor too far behind it.
    rt_bad  = rt_en_q &&
              ((origin_seconds_i > local_seconds_i) ||
               ((origin_seconds_i == local_seconds_i) &&
                (origin_subcount_i > {16'd0, local_subcount_i})) ||
               (rt_diff > 32'(MAX_ROUNDTRIP_SEC)));
    s1_d.ok     = hdr_ok && !rt_bad;
    s1_d.secs   = tsec - epoch_q;
    s1_d.psum_a = (tfrac >> 1) + (tfrac >> 2) + (tfrac >> 3) + (tfrac >> 4);
    s1_d.psum_b = (tfrac >> 6) + (tfrac >> 11) + (tfrac >> 15) + ROUND_HALF;
    s1_d.diff   = rt_diff[DIFF_W-1:0];
    s1_d.lsub   = local_subcount_i;
    s1_d.osub   = origin_subcount_i;
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Stage 2: finish the timer count and form the round-trip delay in counts.
  logic [DIFF_W+16:0] rt_mult;
  s2_t                s2_d;
  s2_t                s2_q;
  logic               s2_vld_q;
  logic [31:0]        fsum;

  always_comb begin
    fsum       = s1_q.psum_a + s1_q.psum_b;
    rt_mult    = (DIFF_W + 17)'(period_q) * (DIFF_W + 17)'(s1_q.diff);
    s2_d.ok    = s1_q.ok;
    s2_d.secs  = s1_q.secs;
    s2_d.count = fsum[31:16];
    s2_d.delay = {16'd0, s1_q.lsub} - s1_q.osub + 32'(rt_mult);
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  // Stage 3: add half the delay to the count and load the divider.
  // Without round-trip correction, or with a zero period, no carry is made
  // and the low half of the total goes out unchanged.
  logic [31:0] total;
  div_stage_t  s3_d;
  div_stage_t  s3_q;
  logic        s3_vld_q;

  always_comb begin
    total = rt_en_q ? ((s2_q.delay >> 1) + {16'd0, s2_q.count}) : {16'd0, s2_q.count};
    s3_d.ok     = s2_q.ok;
    s3_d.do_div = rt_en_q && (period_q != 17'd0);
    s3_d.secs   = s2_q.secs;
    s3_d.byp    = total[15:0];
    s3_d.rem    = 17'd0;
    s3_d.num    = total;
    s3_d.quo    = 32'd0;
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  // Divider stages: quotient bits of total / period, most significant first.
  div_stage_t div_q     [DIV_STAGES];
  logic       div_vld_q [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    div_q[0] <= div_step(s3_q, period_q);
    for (int k = 1; k < DIV_STAGES; k++) begin
      div_q[k] <= div_step(div_q[k-1], period_q);
    end
  end

  // Final stage: carry whole periods into the seconds and clear a refusal.
  div_stage_t  dl;
  logic [31:0] out_secs_d;
  logic [15:0] out_sub_d;
  logic        done_q;
  logic        valid_res_q;
  logic [31:0] new_seconds_q;
  logic [15:0] new_subcount_q;

  always_comb begin
    dl = div_q[DIV_STAGES-1];
    if (!dl.ok) begin
      out_secs_d = 32'd0;
      out_sub_d  = 16'd0;
    end else if (dl.do_div) begin
      out_secs_d = dl.secs + dl.quo;
      out_sub_d  = dl.rem[15:0];
    end else begin
      out_secs_d = dl.secs;
      out_sub_d  = dl.byp;
    end
  end

  always_ff @(posedge clk_i) begin
    valid_res_q    <= dl.ok;
    new_seconds_q  <= out_secs_d;
    new_subcount_q <= out_sub_d;
  end

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        div_vld_q[k] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      s1_vld_q     <= accept;
      s2_vld_q     <= s1_vld_q;
      s3_vld_q     <= s2_vld_q;
      div_vld_q[0] <= s3_vld_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        div_vld_q[k] <= div_vld_q[k-1];
      end
      done_q <= div_vld_q[DIV_STAGES-1];
    end
  end

  assign done_o         = done_q;
  assign valid_res_o    = valid_res_q;
  assign new_seconds_o  = new_seconds_q;
  assign new_subcount_o = new_subcount_q;

  // A result strobe only appears for a word that was accepted.
  `SRTE_ASSERT(a_done_latency, clk_i, rst_ni, done_o, $past(start_i, LAT_EDGES))
  // A refused reply carries zero time.
  `SRTE_ASSERT(a_refused_zero, clk_i, rst_ni, done_o && !valid_res_o,
               new_seconds_o == 32'd0 && new_subcount_o == 16'd0)
  // The divider keeps its remainder below the period.
  `SRTE_ASSERT(a_rem_below_period, clk_i, rst_ni,
               div_vld_q[DIV_STAGES-1] && dl.do_div, dl.rem < period_q)
  // Without round-trip correction the timer count stays inside one second.
  `SRTE_ASSERT(a_count_range, clk_i, rst_ni, done_o && valid_res_o && !rt_en_q,
               new_subcount_o <= 16'd62498)
  // A wrong length is refused as soon as it enters the pipeline.
  `SRTE_ASSERT_NEXT(a_len_refused, clk_i, rst_ni, accept && packet_length_i != LEN_SNTP,
                    s1_vld_q && !s1_q.ok)

endmodule
